// ----- rtl/hbps_pkg.sv -----
`timescale 1ns / 1ps

package hbps_pkg;

  // Bay content IDs
  localparam logic [2:0] ID_FLOPPY     = 3'd0;
  localparam logic [2:0] ID_FLOPPY_ALT = 3'd1;
  localparam logic [2:0] ID_CDROM      = 3'd3;
  localparam logic [2:0] ID_PCI        = 3'd5;
  localparam logic [2:0] ID_SOUND      = 3'd6;
  localparam logic [2:0] ID_EMPTY      = 3'd7;

  // Chip variants
  localparam logic [1:0] VARIANT_FIRST  = 2'd0;
  localparam logic [1:0] VARIANT_SECOND = 2'd1;

  // Default parameters
  localparam int MAX_RETRIES_DEF = 3;
  localparam int TIME_WIDTH_DEF  = 16;

  // Retry counter saturates here
  localparam logic [2:0] RETRY_SAT = 3'd7;

  // Config register defaults
  localparam logic [1:0]  CHIP_VARIANT_RST   = 2'd0;
  localparam logic [7:0]  POLL_MS_RST        = 8'd25;
  localparam logic [15:0] STABLE_MS_RST      = 16'd100;
  localparam logic [15:0] POWER_MS_RST       = 16'd200;
  localparam logic [15:0] RESET_HOLD_MS_RST  = 16'd50;
  localparam logic [15:0] SETUP_MS_RST       = 16'd100;
  localparam logic [15:0] IDE_WAIT_MS_RST    = 16'd1000;
  localparam logic [15:0] IDE_TIMEOUT_MS_RST = 16'd5000;

  // Config register indexes
  typedef enum logic [2:0] {
    REG_CHIP_VARIANT   = 3'd0,
    REG_POLL_MS        = 3'd1,
    REG_STABLE_MS      = 3'd2,
    REG_POWER_MS       = 3'd3,
    REG_RESET_HOLD_MS  = 3'd4,
    REG_SETUP_MS       = 3'd5,
    REG_IDE_WAIT_MS    = 3'd6,
    REG_IDE_TIMEOUT_MS = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  chip_variant;
    logic [7:0]  poll_ms;
    logic [15:0] stable_ms;
    logic [15:0] power_ms;
    logic [15:0] reset_hold_ms;
    logic [15:0] setup_ms;
    logic [15:0] ide_wait_ms;
    logic [15:0] ide_timeout_ms;
  } cfg_t;

  // Bay phase, one-hot
  typedef enum logic [7:0] {
    PH_EMPTY   = 8'b0000_0001,
    PH_PWRUP   = 8'b0000_0010,
    PH_ENABLE  = 8'b0000_0100,
    PH_RESET   = 8'b0000_1000,
    PH_IDERST  = 8'b0001_0000,
    PH_IDEWAIT = 8'b0010_0000,
    PH_UP      = 8'b0100_0000,
    PH_PWRDN   = 8'b1000_0000
  } phase_t;

  // Phase codes as reported on the output
  localparam logic [2:0] CODE_EMPTY   = 3'd0;
  localparam logic [2:0] CODE_PWRUP   = 3'd1;
  localparam logic [2:0] CODE_ENABLE  = 3'd2;
  localparam logic [2:0] CODE_RESET   = 3'd3;
  localparam logic [2:0] CODE_IDERST  = 3'd4;
  localparam logic [2:0] CODE_IDEWAIT = 3'd5;
  localparam logic [2:0] CODE_UP      = 3'd6;
  localparam logic [2:0] CODE_PWRDN   = 3'd7;

  // One result beat, highest field first
  typedef struct packed {
    logic [2:0] bay_content;
    logic [2:0] bay_phase;
    logic       retries_exhausted;
    logic       ide_unregister_req;
    logic       ide_register_req;
    logic       release_ide_reset;
    logic       release_bay_reset;
    logic [2:0] bus_device;
    logic       bus_enable;
    logic       power_down_cmd;
    logic       power_up_cmd;
  } res_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] c;
    case (ph)
      PH_EMPTY:   c = CODE_EMPTY;
      PH_PWRUP:   c = CODE_PWRUP;
      PH_ENABLE:  c = CODE_ENABLE;
      PH_RESET:   c = CODE_RESET;
      PH_IDERST:  c = CODE_IDERST;
      PH_IDEWAIT: c = CODE_IDEWAIT;
      PH_UP:      c = CODE_UP;
      PH_PWRDN:   c = CODE_PWRDN;
      default:    c = CODE_EMPTY;
    endcase
    return c;
  endfunction

  // Devices whose bus the chip variant can enable; variant 3 acts as 2
  function automatic logic bus_supported(logic [1:0] variant, logic [2:0] id);
    logic ok;
    if (variant == VARIANT_FIRST || variant == VARIANT_SECOND) begin
      ok = id inside {ID_FLOPPY, ID_FLOPPY_ALT, ID_CDROM, ID_PCI};
    end else begin
      ok = id inside {ID_CDROM, ID_PCI, ID_SOUND};
    end
    return ok;
  endfunction

endpackage

// ----- rtl/hbps_cfg.sv -----
`timescale 1ns / 1ps

module hbps_cfg import hbps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // Register file, written one register per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chip_variant   <= CHIP_VARIANT_RST;
      cfg.poll_ms        <= POLL_MS_RST;
      cfg.stable_ms      <= STABLE_MS_RST;
      cfg.power_ms       <= POWER_MS_RST;
      cfg.reset_hold_ms  <= RESET_HOLD_MS_RST;
      cfg.setup_ms       <= SETUP_MS_RST;
      cfg.ide_wait_ms    <= IDE_WAIT_MS_RST;
      cfg.ide_timeout_ms <= IDE_TIMEOUT_MS_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_CHIP_VARIANT:   cfg.chip_variant   <= cfg_data[1:0];
        REG_POLL_MS:        cfg.poll_ms        <= cfg_data[7:0];
        REG_STABLE_MS:      cfg.stable_ms      <= cfg_data;
        REG_POWER_MS:       cfg.power_ms       <= cfg_data;
        REG_RESET_HOLD_MS:  cfg.reset_hold_ms  <= cfg_data;
        REG_SETUP_MS:       cfg.setup_ms       <= cfg_data;
        REG_IDE_WAIT_MS:    cfg.ide_wait_ms    <= cfg_data;
        REG_IDE_TIMEOUT_MS: cfg.ide_timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/hbps_step.sv -----
`timescale 1ns / 1ps

module hbps_step import hbps_pkg::*; #(
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int MAX_RETRIES = MAX_RETRIES_DEF
) (
  input  cfg_t                  cfg,
  input  logic [2:0]            sensed_id,
  input  logic                  ide_busy,
  input  logic                  ide_attached,
  input  logic                  ide_register_ok,
  input  phase_t                phase,
  input  logic [2:0]            accepted_id,
  input  logic [2:0]            previous_sample,
  input  logic [TIME_WIDTH-1:0] stable_time,
  input  logic [TIME_WIDTH-1:0] wait_timer,
  input  logic                  ide_registered,
  input  logic [2:0]            retry_count,
  output phase_t                phase_next,
  output logic [2:0]            accepted_id_next,
  output logic [2:0]            previous_sample_next,
  output logic [TIME_WIDTH-1:0] stable_time_next,
  output logic [TIME_WIDTH-1:0] wait_timer_next,
  output logic                  ide_registered_next,
  output logic [2:0]            retry_count_next,
  output res_t                  res
);

  localparam int TW = TIME_WIDTH;
  localparam int CW = (TW > 16) ? TW : 16;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  // Clamp a 16-bit millisecond setting into the timer width
  function automatic logic [TW-1:0] sat_cfg(logic [15:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve > CW'(TMAX)) begin
      return TMAX;
    end
    return TW'(ve);
  endfunction

  logic [TW-1:0] poll_w;
  logic [TW:0]   st_sum;
  logic [2:0]    target;
  logic          run;

  assign poll_w = TW'(cfg.poll_ms);

  always_comb begin
    phase_next           = phase;
    accepted_id_next     = accepted_id;
    previous_sample_next = previous_sample;
    stable_time_next     = stable_time;
    wait_timer_next      = wait_timer;
    ide_registered_next  = ide_registered;
    retry_count_next     = retry_count;
    res                  = '0;
    st_sum               = '0;
    target               = sensed_id;
    run                  = 1'b1;

    // Debounce the content ID; not sampled while powering down
    if (phase != PH_PWRDN) begin
      if (sensed_id != previous_sample) begin
        previous_sample_next = sensed_id;
        stable_time_next     = '0;
      end else if (sensed_id != accepted_id) begin
        st_sum           = {1'b0, stable_time} + {1'b0, poll_w};
        stable_time_next = st_sum[TW] ? TMAX : st_sum[TW-1:0];
        if (CW'(stable_time_next) >= CW'(cfg.stable_ms)) begin
          // type change goes through empty first
          if (sensed_id != ID_EMPTY && accepted_id != ID_EMPTY) begin
            target = ID_EMPTY;
          end
          if (target != ID_EMPTY) begin
            res.power_up_cmd = 1'b1;
            phase_next       = PH_PWRUP;
          end else begin
            res.power_down_cmd = 1'b1;
            phase_next         = PH_PWRDN;
            retry_count_next   = '0;
          end
          wait_timer_next  = sat_cfg(cfg.power_ms);
          accepted_id_next = target;
        end
      end
    end

    // Generic wait timer; the IDE busy wait runs its own countdown
    if (phase_next != PH_IDEWAIT && wait_timer_next != '0) begin
      if (wait_timer_next > poll_w) begin
        wait_timer_next = wait_timer_next - poll_w;
        run             = 1'b0;
      end else begin
        wait_timer_next = '0;
      end
    end

    // Sequencer step
    if (run) begin
      case (phase_next)
        PH_PWRUP: begin
          if (!bus_supported(cfg.chip_variant, previous_sample_next)) begin
            res.power_down_cmd = 1'b1;
            phase_next         = PH_PWRDN;
            wait_timer_next    = sat_cfg(cfg.power_ms);
          end else begin
            res.bus_enable  = 1'b1;
            res.bus_device  = previous_sample_next;
            wait_timer_next = sat_cfg(cfg.reset_hold_ms);
            phase_next      = PH_ENABLE;
          end
        end
        PH_ENABLE: begin
          res.release_bay_reset = 1'b1;
          wait_timer_next       = sat_cfg(cfg.setup_ms);
          phase_next            = PH_RESET;
        end
        PH_RESET: begin
          if (accepted_id_next != ID_CDROM) begin
            phase_next = PH_UP;
          end else begin
            res.release_ide_reset = 1'b1;
            wait_timer_next       = sat_cfg(cfg.ide_wait_ms);
            phase_next            = PH_IDERST;
          end
        end
        PH_IDERST: begin
          wait_timer_next = sat_cfg(cfg.ide_timeout_ms);
          phase_next      = PH_IDEWAIT;
        end
        PH_IDEWAIT: begin
          if (!ide_attached) begin
            wait_timer_next = '0;
            phase_next      = PH_UP;
          end else if (!ide_busy) begin
            wait_timer_next = '0;
            phase_next      = PH_UP;
            if (!ide_registered_next) begin
              res.ide_register_req = 1'b1;
              ide_registered_next  = ide_register_ok;
            end
            // failed registration: count a retry and power down
            if (!ide_registered_next) begin
              if (retry_count_next < RETRY_SAT) begin
                retry_count_next = retry_count_next + 3'd1;
              end
              res.power_down_cmd = 1'b1;
              phase_next         = PH_PWRDN;
              wait_timer_next    = sat_cfg(cfg.power_ms);
            end
          end else begin
            if (wait_timer_next > poll_w) begin
              wait_timer_next = wait_timer_next - poll_w;
            end else begin
              // timeout: power down with no settle wait
              wait_timer_next    = '0;
              res.power_down_cmd = 1'b1;
              phase_next         = PH_PWRDN;
            end
          end
        end
        PH_PWRDN: begin
          phase_next = PH_EMPTY;
          if (ide_registered_next) begin
            res.ide_unregister_req = 1'b1;
            ide_registered_next    = 1'b0;
          end
          if (retry_count_next != '0) begin
            if (retry_count_next > 3'(MAX_RETRIES)) begin
              res.retries_exhausted = 1'b1;
            end else begin
              accepted_id_next = ID_EMPTY;
            end
          end
        end
        default: ;
      endcase
    end

    res.bay_phase   = phase_code(phase_next);
    res.bay_content = accepted_id_next;
  end

endmodule

// ----- rtl/hotplug_bay_power_sequencer.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  one poll tick (s_tdata)
// m_*       out  m_tvalid/m_tready  one result per tick (m_tdata)
// cfg_*     in   cfg_we             register write, index and data
//
// One tick per cycle sustained while m_tready stays high; a result passes through
// the input register, then the result register. The tick-to-tick state loop
// closes through the combinational hbps_step.
// rst is synchronous: control state, phase and config registers return to
// their defaults. A stalled m_tready holds the result; the input register
// still takes one more tick before s_tready drops.

module hotplug_bay_power_sequencer import hbps_pkg::*; #(
  parameter int MAX_RETRIES = MAX_RETRIES_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] sensed_id, [3] ide_busy, [4] ide_attached, [5] ide_register_ok
  input  logic [7:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] power_up_cmd, [1] power_down_cmd, [2] bus_enable, [5:3] bus_device,
  // [6] release_bay_reset, [7] release_ide_reset, [8] ide_register_req,
  // [9] ide_unregister_req, [10] retries_exhausted, [13:11] bay_phase,
  // [16:14] bay_content, [23:17] zero
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg;

  hbps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  logic       in_valid;
  logic [5:0] in_data;
  // Result register
  logic       out_valid;
  res_t       out_res;
  logic       move;

  // Sequencer state
  phase_t                phase, phase_next;
  logic [2:0]            accepted_id, accepted_id_next;
  logic [2:0]            previous_sample, previous_sample_next;
  logic [TIME_WIDTH-1:0] stable_time, stable_time_next;
  logic [TIME_WIDTH-1:0] wait_timer, wait_timer_next;
  logic                  ide_registered, ide_registered_next;
  logic [2:0]            retry_count, retry_count_next;
  res_t                  res;

  assign move     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || move;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_res};

  hbps_step #(
    .TIME_WIDTH  (TIME_WIDTH),
    .MAX_RETRIES (MAX_RETRIES)
  ) u_step (
    .cfg                  (cfg),
    .sensed_id            (in_data[2:0]),
    .ide_busy             (in_data[3]),
    .ide_attached         (in_data[4]),
    .ide_register_ok      (in_data[5]),
    .phase                (phase),
    .accepted_id          (accepted_id),
    .previous_sample      (previous_sample),
    .stable_time          (stable_time),
    .wait_timer           (wait_timer),
    .ide_registered       (ide_registered),
    .retry_count          (retry_count),
    .phase_next           (phase_next),
    .accepted_id_next     (accepted_id_next),
    .previous_sample_next (previous_sample_next),
    .stable_time_next     (stable_time_next),
    .wait_timer_next      (wait_timer_next),
    .ide_registered_next  (ide_registered_next),
    .retry_count_next     (retry_count_next),
    .res                  (res)
  );

  // Beat flow and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      phase           <= PH_EMPTY;
      accepted_id     <= ID_EMPTY;
      previous_sample <= ID_EMPTY;
      stable_time     <= '0;
      wait_timer      <= '0;
      ide_registered  <= 1'b0;
      retry_count     <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (move) begin
        in_valid <= 1'b0;
      end
      if (move) begin
        out_valid       <= 1'b1;
        phase           <= phase_next;
        accepted_id     <= accepted_id_next;
        previous_sample <= previous_sample_next;
        stable_time     <= stable_time_next;
        wait_timer      <= wait_timer_next;
        ide_registered  <= ide_registered_next;
        retry_count     <= retry_count_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata[5:0];
    end
    if (move) begin
      out_res <= res;
    end
  end

endmodule
